// File: rtl/pmra_pkg.sv
`default_nettype none

package pmra_pkg;

    localparam int FUNC_W  = 3;
    localparam int DELTA_W = 32;
    localparam int PEND_W  = 21;
    localparam int REP_W   = 16;

    localparam logic signed [PEND_W-1:0] PEND_MAX  = 21'sd1000000;
    localparam logic signed [PEND_W-1:0] PEND_MIN  = -21'sd1000000;
    localparam logic signed [REP_W-1:0]  CHUNK_MAX = 16'sd32767;
    localparam logic signed [REP_W-1:0]  CHUNK_MIN = -16'sd32767;

    // event codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_MOVE      = 3'd0,
        FN_DONE      = 3'd1,
        FN_REJECT    = 3'd2,
        FN_READY     = 3'd3,
        FN_SUSPEND   = 3'd4,
        FN_BUS_RESET = 3'd5
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
        logic                      level;
    } t_item;

    // pending sum plus a delta, saturated at the pending limits
    function automatic logic signed [PEND_W-1:0] sat_add(
        input logic signed [PEND_W-1:0]  acc,
        input logic signed [DELTA_W-1:0] d
    );
        logic signed [DELTA_W:0] s;
        s = (DELTA_W+1)'(acc) + (DELTA_W+1)'(d);
        if (s > (DELTA_W+1)'(PEND_MAX)) begin
            return PEND_MAX;
        end else if (s < (DELTA_W+1)'(PEND_MIN)) begin
            return PEND_MIN;
        end
        return s[PEND_W-1:0];
    endfunction

    // portion of a pending sum that fits one report
    function automatic logic signed [REP_W-1:0] chunk_of(
        input logic signed [PEND_W-1:0] acc
    );
        if (acc > PEND_W'(CHUNK_MAX)) begin
            return CHUNK_MAX;
        end else if (acc < PEND_W'(CHUNK_MIN)) begin
            return CHUNK_MIN;
        end
        return acc[REP_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/pmra_in_reg.sv
`default_nettype none

module pmra_in_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire pmra_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire logic            i_take,
    output pmra_pkg::t_item      o_item
);

    logic            r_valid;
    logic            n_valid;
    pmra_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pmra_core.sv
`default_nettype none

module pmra_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic                             i_cfg_wr_data,
    input  wire logic                             i_valid,
    input  wire pmra_pkg::t_item                  i_item,
    output logic                                  o_take,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic signed [pmra_pkg::REP_W-1:0]     o_report_x,
    output logic signed [pmra_pkg::REP_W-1:0]     o_report_y
);

    logic signed [pmra_pkg::PEND_W-1:0] r_pend_x, n_pend_x;
    logic signed [pmra_pkg::PEND_W-1:0] r_pend_y, n_pend_y;
    logic signed [pmra_pkg::REP_W-1:0]  r_sent_x, n_sent_x;
    logic signed [pmra_pkg::REP_W-1:0]  r_sent_y, n_sent_y;
    logic r_iface_ready, n_iface_ready;
    logic r_in_flight, n_in_flight;
    logic r_suspended, n_suspended;
    logic r_enable, n_enable;
    logic r_out_valid, n_out_valid;
    logic signed [pmra_pkg::REP_W-1:0]  r_rep_x, r_rep_y;

    logic signed [pmra_pkg::PEND_W-1:0] a_pend_x, a_pend_y;
    logic signed [pmra_pkg::REP_W-1:0]  c_x, c_y;
    logic a_in_flight, a_suspended, a_ready, try_send, send, fire;

    assign fire        = i_valid && (!r_out_valid || i_out_ready);
    assign o_take      = fire;
    assign o_out_valid = r_out_valid;
    assign o_report_x  = r_rep_x;
    assign o_report_y  = r_rep_y;

    // event effect on the state, before the send attempt
    always_comb begin
        a_pend_x    = r_pend_x;
        a_pend_y    = r_pend_y;
        a_in_flight = r_in_flight;
        a_suspended = r_suspended;
        a_ready     = r_iface_ready;
        try_send    = 1'b0;
        unique case (pmra_pkg::t_func'(i_item.func))
            pmra_pkg::FN_MOVE: begin
                if ((i_item.delta_x != '0 || i_item.delta_y != '0)
                        && r_enable && r_iface_ready) begin
                    a_pend_x = pmra_pkg::sat_add(r_pend_x, i_item.delta_x);
                    a_pend_y = pmra_pkg::sat_add(r_pend_y, i_item.delta_y);
                    try_send = 1'b1;
                end
            end
            pmra_pkg::FN_DONE: begin
                a_in_flight = 1'b0;
                try_send    = 1'b1;
            end
            pmra_pkg::FN_REJECT: begin
                if (r_in_flight) begin
                    a_pend_x = pmra_pkg::sat_add(r_pend_x,
                                                 pmra_pkg::DELTA_W'(r_sent_x));
                    a_pend_y = pmra_pkg::sat_add(r_pend_y,
                                                 pmra_pkg::DELTA_W'(r_sent_y));
                    a_in_flight = 1'b0;
                end
            end
            pmra_pkg::FN_READY: begin
                a_ready     = i_item.level;
                a_in_flight = 1'b0;
                a_pend_x    = '0;
                a_pend_y    = '0;
            end
            pmra_pkg::FN_SUSPEND: begin
                a_suspended = i_item.level;
                try_send    = !i_item.level;
            end
            pmra_pkg::FN_BUS_RESET: begin
                a_suspended = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign c_x  = pmra_pkg::chunk_of(a_pend_x);
    assign c_y  = pmra_pkg::chunk_of(a_pend_y);
    assign send = try_send && a_ready && !a_in_flight && !a_suspended
                  && (a_pend_x != '0 || a_pend_y != '0);

    always_comb begin
        n_pend_x      = r_pend_x;
        n_pend_y      = r_pend_y;
        n_sent_x      = r_sent_x;
        n_sent_y      = r_sent_y;
        n_iface_ready = r_iface_ready;
        n_in_flight   = r_in_flight;
        n_suspended   = r_suspended;
        n_enable      = r_enable;
        n_out_valid   = r_out_valid && !i_out_ready;
        if (fire) begin
            n_iface_ready = a_ready;
            n_suspended   = a_suspended;
            n_out_valid   = send;
            if (send) begin
                n_pend_x    = a_pend_x - pmra_pkg::PEND_W'(c_x);
                n_pend_y    = a_pend_y - pmra_pkg::PEND_W'(c_y);
                n_sent_x    = c_x;
                n_sent_y    = c_y;
                n_in_flight = 1'b1;
            end else begin
                n_pend_x    = a_pend_x;
                n_pend_y    = a_pend_y;
                n_in_flight = a_in_flight;
            end
        end
        if (i_cfg_wr_en) begin
            n_enable = i_cfg_wr_data;
            if (!i_cfg_wr_data) begin
                n_pend_x = '0;
                n_pend_y = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_x      <= '0;
            r_pend_y      <= '0;
            r_sent_x      <= '0;
            r_sent_y      <= '0;
            r_iface_ready <= 1'b0;
            r_in_flight   <= 1'b0;
            r_suspended   <= 1'b0;
            r_enable      <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_pend_x      <= n_pend_x;
            r_pend_y      <= n_pend_y;
            r_sent_x      <= n_sent_x;
            r_sent_y      <= n_sent_y;
            r_iface_ready <= n_iface_ready;
            r_in_flight   <= n_in_flight;
            r_suspended   <= n_suspended;
            r_enable      <= n_enable;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && send) begin
            r_rep_x <= c_x;
            r_rep_y <= c_y;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pointer_motion_report_accumulator.sv
`default_nettype none
// path: an event transaction passes the input register, then the result register, before its report leaves
// throughput: one event transaction per cycle while the report side keeps up
// the state update is one pass of add, saturate and clamp between the two registers
// reset: synchronous active low; pending sums, flags and sent motion clear, cursor enable sets
// events that give no report still pass through the result stage in order

module pointer_motion_report_accumulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // cursor enable register
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    // event stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,   // delta_x[31:0], delta_y[63:32], level[64]
    input  wire logic [2:0]  i_s_axis_tuser,   // func[2:0]
    // report stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // report_x[15:0], report_y[31:16]
);

    pmra_pkg::t_item s_item;
    pmra_pkg::t_item q_item;
    logic            q_valid;
    logic            q_take;
    logic signed [pmra_pkg::REP_W-1:0] rep_x;
    logic signed [pmra_pkg::REP_W-1:0] rep_y;

    // unpack the incoming transaction; tdata bits above level are padding
    always_comb begin
        s_item.func    = i_s_axis_tuser;
        s_item.delta_x = i_s_axis_tdata[31:0];
        s_item.delta_y = i_s_axis_tdata[63:32];
        s_item.level   = i_s_axis_tdata[64];
    end

    // input register, refilled in the same cycle the core consumes it
    pmra_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (s_item),
        .o_valid (q_valid),
        .i_take  (q_take),
        .o_item  (q_item)
    );

    // event decode, saturating accumulate, send attempt and report register
    pmra_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (q_valid),
        .i_item        (q_item),
        .o_take        (q_take),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_report_x    (rep_x),
        .o_report_y    (rep_y)
    );

    assign o_m_axis_tdata = {rep_y, rep_x};

endmodule

`default_nettype wire
